### design/btra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btra_pkg: shared types and constants for the beacon RSSI averager
// Table geometry, arithmetic widths, beat payload structs and sequencer states.
// ----------------------------------------------------------------------------
package btra_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int WINDOW_LENGTH = 5;

  localparam int ADDR_W     = 48;
  localparam int KIND_W     = 2;
  localparam int RSSI_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int SLOT_NUM_W = 4;
  localparam int CID_W      = 16;

  localparam logic [CID_W-1:0] CID_RESET = 16'hAFAF;

  localparam int SLOT_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int POS_W      = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FILL_W     = $clog2(WINDOW_LENGTH + 1);
  localparam int RING_DEPTH = TABLE_ENTRIES * WINDOW_LENGTH;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Window sum and constant reciprocal for the truncating divide
  localparam int SUM_W   = RSSI_W + $clog2(WINDOW_LENGTH);
  localparam int MAG_W   = SUM_W;
  localparam int DIV_K   = MAG_W + $clog2(WINDOW_LENGTH);
  localparam int RECIP_W = DIV_K + 1;
  localparam int RECIP   = (2 ** DIV_K + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int PROD_W  = MAG_W + RECIP_W;

  typedef struct packed {
    logic [ADDR_W-1:0]        device_address;
    logic [KIND_W-1:0]        address_kind;
    logic signed [RSSI_W-1:0] rssi_sample;
    logic                     mfr_present;
    logic [BYTE_W-1:0]        mfr_first;
    logic [BYTE_W-1:0]        mfr_second;
  } rpt_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        out_address;
    logic [KIND_W-1:0]        out_kind;
    logic [SLOT_NUM_W-1:0]    slot_number;
    logic signed [RSSI_W-1:0] average_rssi;
  } avg_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_MUL    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

endpackage

### design/beacon_table_rssi_averager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_table_rssi_averager_core: per-device RSSI moving-average table
// Filters reports by company identifier, finds or claims a device slot and
// reports the truncated average of that device's last samples.
// ----------------------------------------------------------------------------
// Usage:
//   rpt channel (rpt_valid / rpt_stall / rpt): one advertisement report per
//   beat. rpt_stall is high while a report is being worked on.
//   avg channel (avg_valid / avg_stall / avg): zero or one result per report.
//   A held result does not block the next report; a report that finishes
//   while the previous result is still stalled waits in its last step.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): company identifier,
//   accepted only while the block is idle.
// Flow: a report with the wrong or missing manufacturer bytes is dropped
//   at the accept edge. Otherwise one comparator walks the table one slot a
//   cycle, the update step updates the slot and writes the sample, the sum
//   step reads and adds the window from the sample RAM, the multiply step
//   multiplies by the reciprocal and the last step loads the result; only
//   then is it ready for the next report. A report for an unknown device
//   with the table full is dropped after the scan.
// Reset: all slots free, ring positions and fill counts zero, company
//   identifier 0xAFAF. No clearing pass: fill counts mask unwritten samples.
// ----------------------------------------------------------------------------
module beacon_table_rssi_averager_core
  import btra_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rpt_valid,
  output logic             rpt_stall,
  input  rpt_t             rpt,
  output logic             avg_valid,
  input  logic             avg_stall,
  output avg_t             avg,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CID_W-1:0] cfg_data
);

  state_t state;

  logic [CID_W-1:0] company_id;
  rpt_t             req;

  // Slot table
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [ADDR_W-1:0]        slot_address [TABLE_ENTRIES];
  logic [KIND_W-1:0]        slot_kind    [TABLE_ENTRIES];
  logic [POS_W-1:0]         ring_pos     [TABLE_ENTRIES];
  logic [FILL_W-1:0]        ring_fill    [TABLE_ENTRIES];

  // Scan results
  logic [SLOT_W-1:0] scan_idx;
  logic              hit_found;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;

  // Window work
  logic [SLOT_W-1:0]       cur_slot;
  logic [FILL_W-1:0]       cur_fill;
  logic [FILL_W-1:0]       sum_cnt;
  logic signed [SUM_W-1:0] sum;
  logic [PROD_W-1:0]       prod;
  logic                    neg;

  logic rpt_beat;
  logic cid_match;
  logic scan_hit;
  logic scan_free;

  logic                    upd_claim;
  logic                    upd_go;
  logic [SLOT_W-1:0]       upd_slot;
  logic [POS_W-1:0]        pos_rd;
  logic [POS_W-1:0]        pos_use;
  logic [POS_W-1:0]        pos_next;
  logic [FILL_W-1:0]       fill_old;
  logic [FILL_W-1:0]       fill_next;
  logic [RING_AW-1:0]      wr_addr;
  logic [RING_AW-1:0]      rd_addr;
  logic                    rd_en;
  logic signed [RSSI_W-1:0] rd_data;
  logic [FILL_W-1:0]       elem;
  logic [MAG_W-1:0]        mag;
  logic [RSSI_W-1:0]       quot;
  logic                    out_load;

  assign rpt_stall = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign rpt_beat  = rpt_valid && !rpt_stall;

  assign cid_match = rpt.mfr_present
                     && (rpt.mfr_first == company_id[BYTE_W-1:0])
                     && (rpt.mfr_second == company_id[CID_W-1:BYTE_W]);

  // Shared comparator: one slot per cycle
  assign scan_hit  = slot_valid[scan_idx]
                     && (slot_address[scan_idx] == req.device_address)
                     && (slot_kind[scan_idx] == req.address_kind);
  assign scan_free = !slot_valid[scan_idx];

  // Slot update decision
  always_comb begin
    upd_claim = !hit_found && free_found;
    upd_go    = hit_found || free_found;
    upd_slot  = hit_found ? hit_slot : free_slot;
    pos_rd    = upd_claim ? '0 : ring_pos[upd_slot];
    fill_old  = upd_claim ? '0 : ring_fill[upd_slot];
    pos_use   = ({1'b0, pos_rd} >= (POS_W + 1)'(WINDOW_LENGTH)) ? '0 : pos_rd;
    pos_next  = (pos_use == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos_use + 1'b1;
    fill_next = (fill_old == FILL_W'(WINDOW_LENGTH)) ? fill_old : fill_old + 1'b1;
    wr_addr   = RING_AW'(upd_slot) * RING_AW'(WINDOW_LENGTH) + RING_AW'(pos_use);
  end

  // Window read: issue entry sum_cnt, add entry sum_cnt-1 arriving from the RAM
  assign rd_en   = (state == ST_SUM) && (sum_cnt != FILL_W'(WINDOW_LENGTH));
  assign rd_addr = RING_AW'(cur_slot) * RING_AW'(WINDOW_LENGTH) + RING_AW'(sum_cnt);
  assign elem    = sum_cnt - 1'b1;

  assign mag      = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  assign quot     = prod[DIV_K +: RSSI_W];
  assign out_load = (state == ST_DONE) && (!avg_valid || !avg_stall);

  btra_ram #(
    .WIDTH (RSSI_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   ((state == ST_UPDATE) && upd_go),
    .wr_addr (wr_addr),
    .wr_data (req.rssi_sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (rpt_beat && cid_match) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx == SLOT_W'(TABLE_ENTRIES - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= upd_go ? ST_SUM : ST_IDLE;
        end
        ST_SUM: begin
          if (sum_cnt == FILL_W'(WINDOW_LENGTH)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      company_id <= CID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      company_id <= cfg_data;
    end
  end

  // Latch the report and walk the table
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (rpt_beat) begin
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      if (scan_hit && !hit_found) begin
        hit_found <= 1'b1;
      end
      if (scan_free && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_beat) begin
      req <= rpt;
    end
    if (state == ST_SCAN) begin
      if (scan_hit && !hit_found) begin
        hit_slot <= scan_idx;
      end
      if (scan_free && !free_found) begin
        free_slot <= scan_idx;
      end
    end
  end

  // Slot state: valid marks, ring positions and fill counts reset at once
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ring_pos[i]  <= '0;
        ring_fill[i] <= '0;
      end
    end else if ((state == ST_UPDATE) && upd_go) begin
      slot_valid[upd_slot] <= 1'b1;
      ring_pos[upd_slot]   <= pos_next;
      ring_fill[upd_slot]  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_UPDATE) && upd_claim) begin
      slot_address[upd_slot] <= req.device_address;
      slot_kind[upd_slot]    <= req.address_kind;
    end
  end

  // Window sum and reciprocal multiply
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      cur_slot <= upd_slot;
      cur_fill <= fill_next;
      sum_cnt  <= '0;
      sum      <= '0;
    end else if (state == ST_SUM) begin
      sum_cnt <= sum_cnt + 1'b1;
      // Entries beyond the fill count were never written: they count as zero
      if ((sum_cnt != '0) && (elem < cur_fill)) begin
        sum <= sum + SUM_W'(rd_data);
      end
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(mag) * PROD_W'(RECIP);
      neg  <= sum[SUM_W-1];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (out_load) begin
      avg_valid <= 1'b1;
    end else if (!avg_stall) begin
      avg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg.out_address  <= req.device_address;
      avg.out_kind     <= req.address_kind;
      avg.slot_number  <= SLOT_NUM_W'(cur_slot);
      avg.average_rssi <= neg ? -quot : quot;
    end
  end

  // Assertions
  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    ((slot_valid & $past(slot_valid)) == $past(slot_valid)))
    else $error("slot valid mark cleared");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(avg_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the final step");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> ((sum <= SUM_W'(127 * WINDOW_LENGTH))
                           && (sum >= -SUM_W'(128 * WINDOW_LENGTH))))
    else $error("window sum out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> ((cur_fill != '0) && (cur_fill <= FILL_W'(WINDOW_LENGTH))))
    else $error("fill count out of range");

endmodule

### design/btra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btra_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
